// File: sv/ddoi_pkg.sv
// package: widths, constants and tables of the odometry integrator
package ddoi_pkg;

    localparam int ANGLE_ITERATIONS_DEFAULT = 16;
    localparam int ATAN_DEPTH = 24;

    localparam logic signed [31:0] Q24_PI      = 32'sd52707179;
    localparam logic signed [31:0] Q24_HALF_PI = 32'sd26353589;
    localparam logic signed [31:0] Q24_TWO_PI  = 32'sd105414357;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // register indexes
    localparam logic [2:0] REG_STEP_TIME     = 3'd0;
    localparam logic [2:0] REG_RADIUS        = 3'd1;
    localparam logic [2:0] REG_START_X       = 3'd2;
    localparam logic [2:0] REG_START_Y       = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;
    localparam logic [2:0] REG_COLL_THRESH   = 3'd5;

    // input mode codes
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef struct packed {
        logic [23:0]        step_time;
        logic [15:0]        radius_q16;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_heading;
        logic signed [15:0] collision_threshold;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] left_wheel_rate;
        logic signed [15:0] right_wheel_rate;
        logic signed [15:0] gyro_rate;
        logic signed [15:0] vertical_accel;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_heading;
        logic               collision;
    } pose_t;

    // arctangent table, Q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// File: sv/ddoi_stream_if.sv
// valid/ready stream interface carrying one payload type
interface ddoi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ddoi_cfg_regs.sv
// APB register file of the odometry integrator
module ddoi_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ddoi_pkg::cfg_t    cfg
);
    ddoi_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time           <= 24'd16777;
            cfg_reg.radius_q16          <= 16'd1311;
            cfg_reg.start_x             <= '0;
            cfg_reg.start_y             <= '0;
            cfg_reg.start_heading       <= '0;
            cfg_reg.collision_threshold <= -16'sd128;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                ddoi_pkg::REG_STEP_TIME:     cfg_reg.step_time <= pwdata[23:0];
                ddoi_pkg::REG_RADIUS:        cfg_reg.radius_q16 <= pwdata[15:0];
                ddoi_pkg::REG_START_X:       cfg_reg.start_x <= pwdata;
                ddoi_pkg::REG_START_Y:       cfg_reg.start_y <= pwdata;
                ddoi_pkg::REG_START_HEADING: cfg_reg.start_heading <= pwdata;
                ddoi_pkg::REG_COLL_THRESH:   cfg_reg.collision_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            ddoi_pkg::REG_STEP_TIME:     prdata = {8'd0, cfg_reg.step_time};
            ddoi_pkg::REG_RADIUS:        prdata = {16'd0, cfg_reg.radius_q16};
            ddoi_pkg::REG_START_X:       prdata = cfg_reg.start_x;
            ddoi_pkg::REG_START_Y:       prdata = cfg_reg.start_y;
            ddoi_pkg::REG_START_HEADING: prdata = cfg_reg.start_heading;
            ddoi_pkg::REG_COLL_THRESH:
                prdata = {{16{cfg_reg.collision_threshold[15]}}, cfg_reg.collision_threshold};
            default:                     prdata = '0;
        endcase
    end
endmodule

// File: sv/diff_drive_odometry_integrator_top.sv
// top level: sequencer, shared CORDIC / multiplier datapath and pose state
//
// A sample item passes through these steps from acceptance until its pose
// is in the output register: compare and subtract steps reduce the heading
// modulo 2*pi, a further step brings it into [-pi, pi), another folds it,
// one CORDIC rotation per step follows on a shared add/shift unit, then a
// sequence of single 32x32 (or narrower) products through one shared
// multiplier, each registered before use. A restart item goes from idle
// straight to the last step, which loads its pose into the output register.
// The input is not ready while an item is at work; a pose still waiting in
// the output register only holds the sequencer in its last step.
module diff_drive_odometry_integrator_top #(
    parameter int ANGLE_ITERATIONS = ddoi_pkg::ANGLE_ITERATIONS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ddoi_stream_if.sink   in_item,
    ddoi_stream_if.source out_item
);
    localparam int NITER = (ANGLE_ITERATIONS < ddoi_pkg::ATAN_DEPTH) ?
                           ANGLE_ITERATIONS : ddoi_pkg::ATAN_DEPTH;
    // |heading| / (2*pi) stays below 32, so shifts of 4 down to 0 suffice
    localparam logic [4:0] RED_TOP = 5'd4;

    ddoi_pkg::cfg_t cfg;

    ddoi_cfg_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED1, ST_RED2, ST_FOLD, ST_ROT, ST_DIST, ST_DX, ST_DY,
        ST_HEAD, ST_SPEED, ST_OUT
    } state_t;

    state_t             state_reg;
    logic [4:0]         iter_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, heading_reg, speed_reg;
    logic signed [15:0] turn_reg;
    logic               coll_reg;
    ddoi_pkg::sample_t  smp_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] rem_reg;
    logic signed [31:0] r_reg;
    logic               neg_reg;
    logic signed [31:0] dist_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    ddoi_pkg::pose_t    out_reg;

    // shared multiplier: operands chosen by state
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DIST:  begin mul_a = 34'(speed_reg); mul_b = {10'd0, cfg.step_time}; end
            ST_DY:    begin mul_a = 34'(dist_reg);  mul_b = cx_reg; end
            ST_HEAD:  begin mul_a = 34'(dist_reg);  mul_b = cy_reg; end
            ST_SPEED: begin mul_a = 34'(turn_reg);  mul_b = {10'd0, cfg.step_time}; end
            ST_OUT:
            begin
                mul_a = 34'(smp_reg.left_wheel_rate) + 34'(smp_reg.right_wheel_rate);
                mul_b = {18'd0, cfg.radius_q16};
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // CORDIC rotation step on the shared add/shift unit
    logic signed [33:0] xs, ys, atn;
    assign xs  = cx_reg >>> iter_reg;
    assign ys  = cy_reg >>> iter_reg;
    assign atn = ddoi_pkg::atan_q30(iter_reg);

    // heading reduction: 2*pi scaled by a power of two, taken off the magnitude when it fits
    logic signed [33:0] red_step;
    assign red_step = 34'(ddoi_pkg::Q24_TWO_PI) <<< iter_reg;

    logic signed [33:0] add_x, add_y, prod_sh;
    assign prod_sh = 34'(prod_reg >>> 30);
    assign add_x   = 34'(pos_x_reg) + prod_sh;
    assign add_y   = 34'(pos_y_reg) + prod_sh;

    // output register free, and pose loaded into it this cycle
    logic out_free;
    logic out_load;
    assign out_free = !out_valid_reg || out_item.ready;
    assign out_load = (state_reg == ST_OUT) && out_free &&
                      ((smp_reg.mode == ddoi_pkg::MODE_RESTART) || (iter_reg != '0));

    assign in_item.ready  = (state_reg == ST_IDLE);
    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_reg;

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            speed_reg     <= '0;
            turn_reg      <= '0;
            coll_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_item.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_item.valid && in_item.ready)
                    begin
                        smp_reg <= in_item.data;
                        if (in_item.data.mode == ddoi_pkg::MODE_RESTART)
                        begin
                            pos_x_reg   <= cfg.start_x;
                            pos_y_reg   <= cfg.start_y;
                            heading_reg <= cfg.start_heading;
                            speed_reg   <= '0;
                            turn_reg    <= '0;
                            coll_reg    <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            if (in_item.data.vertical_accel > cfg.collision_threshold)
                                coll_reg <= 1'b1;
                            rem_reg   <= 34'(heading_reg);
                            iter_reg  <= RED_TOP;
                            state_reg <= ST_RED1;
                        end
                    end
                end
                ST_RED1:
                begin
                    // remainder by 2*pi, keeps the sign of the heading
                    if (!rem_reg[33])
                    begin
                        if (rem_reg >= red_step)
                            rem_reg <= rem_reg - red_step;
                    end
                    else if (-rem_reg >= red_step)
                        rem_reg <= rem_reg + red_step;
                    if (iter_reg == '0)
                        state_reg <= ST_RED2;
                    else
                        iter_reg <= iter_reg - 5'd1;
                end
                ST_RED2:
                begin
                    if (rem_reg >= 34'(ddoi_pkg::Q24_PI))
                        r_reg <= 32'(rem_reg - 34'(ddoi_pkg::Q24_TWO_PI));
                    else if (rem_reg < -34'(ddoi_pkg::Q24_PI))
                        r_reg <= 32'(rem_reg + 34'(ddoi_pkg::Q24_TWO_PI));
                    else
                        r_reg <= rem_reg[31:0];
                    state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    if (r_reg > ddoi_pkg::Q24_HALF_PI)
                    begin
                        cz_reg  <= 34'(r_reg - ddoi_pkg::Q24_PI) <<< 6;
                        neg_reg <= 1'b1;
                    end
                    else if (r_reg < -ddoi_pkg::Q24_HALF_PI)
                    begin
                        cz_reg  <= 34'(r_reg + ddoi_pkg::Q24_PI) <<< 6;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg  <= 34'(r_reg) <<< 6;
                        neg_reg <= 1'b0;
                    end
                    cx_reg    <= ddoi_pkg::CORDIC_GAIN;
                    cy_reg    <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atn;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atn;
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'(NITER - 1))
                        state_reg <= ST_DIST;
                end
                ST_DIST:
                begin
                    if (neg_reg)
                    begin
                        cx_reg <= -cx_reg;
                        cy_reg <= -cy_reg;
                    end
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_DX;
                end
                ST_DX:
                begin
                    dist_reg  <= prod_reg[55:24];
                    state_reg <= ST_DY;
                end
                ST_DY:
                begin
                    // distance times cosine
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_HEAD;
                end
                ST_HEAD:
                begin
                    pos_x_reg <= ddoi_pkg::sat32(add_x);
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_SPEED;
                end
                ST_SPEED:
                begin
                    pos_y_reg <= ddoi_pkg::sat32(add_y);
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_OUT;
                    iter_reg  <= '0;
                end
                ST_OUT:
                begin
                    if ((smp_reg.mode == ddoi_pkg::MODE_SAMPLE) && (iter_reg == '0))
                    begin
                        // heading step, speed product started
                        heading_reg <= ddoi_pkg::sat32(34'(heading_reg)
                                       + 34'(prod_reg >>> 8));
                        prod_reg    <= mul_p[63:0];
                        iter_reg    <= 5'd1;
                    end
                    else if (out_free)
                    begin
                        if (smp_reg.mode == ddoi_pkg::MODE_SAMPLE)
                        begin
                            speed_reg <= prod_reg[40:9];
                            turn_reg  <= smp_reg.gyro_rate;
                        end
                        out_reg   <= '{pose_x: pos_x_reg, pose_y: pos_y_reg,
                                       pose_heading: heading_reg,
                                       collision: coll_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // products stay within 64 bits, so the top bits of mul_p are unused
    wire unused_ok = &{1'b1, mul_p[67:64]};

    ast_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    ast_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_item.valid && in_item.ready) |=> !in_item.ready)
        else $error("accepted twice");
    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item.ready) |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped");
    ast_iter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> iter_reg < 5'(NITER))
        else $error("cordic overrun");
endmodule
